[sv/gdrf_pkg.sv]
// shared types and constants of the gps dead-reckoning fusion core
package gdrf_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int YAW_DROP   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
   localparam logic [15:0] YAW_MASK = 16'(16'hFFFF << YAW_DROP);

   localparam int MUL_BITS = 32;
   localparam int DIV_BITS = 64;

   localparam logic [44:0] DR_DEN    = 45'd32768000000000;
   localparam logic [44:0] GAIN_DEN  = 45'd107374182400;
   localparam logic [63:0] DR_HALF   = 64'(DR_DEN / 2);
   localparam logic [63:0] GAIN_HALF = 64'(GAIN_DEN / 2);

   localparam logic [16:0] SIN_QUAD_ONE = 17'd65536;
   localparam logic [31:0] SIN_C3       = 32'd4640;
   localparam logic [16:0] SIN_C2       = 17'd42047;
   localparam logic [16:0] SIN_C1       = 17'd102944;
   localparam logic [16:0] SIN_MAX      = 17'd32767;
   localparam logic [31:0] GAIN_NUM     = 32'd45;

   localparam logic signed [63:0] FWD_HI        = 64'sd24576000;
   localparam logic signed [63:0] FWD_LO_MOVING = -64'sd1638400;
   localparam logic signed [63:0] FWD_LO_STILL  = -64'sd9830400;
   localparam logic signed [63:0] LAT_HI        = 64'sd9830400;
   localparam logic signed [63:0] LAT_LO        = -64'sd9830400;

   localparam logic signed [39:0] POS_MAX = 40'sh7FFFFFFFFF;
   localparam logic signed [39:0] POS_MIN = 40'sh8000000000;

   localparam logic [29:0] MAX_PRED_RESET = 30'd100000000;

   localparam logic [1:0] CSR_EAST_OFFSET  = 2'd0;
   localparam logic [1:0] CSR_NORTH_OFFSET = 2'd1;
   localparam logic [1:0] CSR_MAX_PRED     = 2'd2;

   typedef enum logic {
      DIV_DR,
      DIV_GAIN
   } div_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SIN_SQ,
      ST_SIN_T1,
      ST_SIN_T2,
      ST_SIN_Y,
      ST_DR_V,
      ST_DR_P,
      ST_DR_D,
      ST_FIX,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_F4,
      ST_C1,
      ST_C2,
      ST_C3,
      ST_C4,
      ST_C5,
      ST_C6,
      ST_C7,
      ST_C8,
      ST_OUT
   } fsm_state_type;

endpackage

[sv/gdrf_mul.sv]
// shift-add serial multiplier, one multiplier bit per cycle, sign applied at the end
module gdrf_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               neg,
   input  logic [47:0]        a_mag,
   input  logic [31:0]        b_mag,
   output logic               done,
   output logic signed [63:0] p
);
   import gdrf_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = neg;
         cnt_in  = 5'(MUL_BITS - 1);
         a_in    = {16'b0, a_mag};
         b_in    = b_mag;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[62:0], 1'b0};
         b_in   = {1'b0, b_ff[31:1]};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign p    = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

endmodule

[sv/gdrf_div.sv]
// restoring divider by one of two fixed divisors, one quotient bit per cycle
module gdrf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  gdrf_pkg::div_sel_type sel,
   input  logic [63:0]          dividend,
   output logic                 done,
   output logic [63:0]          quotient
);
   import gdrf_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [44:0] rem_ff, rem_in;
   logic [44:0] den_ff, den_in;
   logic [45:0] sh;
   logic [45:0] diff;
   logic        ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   always_comb begin
      sh      = {rem_ff, dvd_ff[63]};
      diff    = sh - {1'b0, den_ff};
      ge      = sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(DIV_BITS - 1);
         dvd_in  = dividend;
         rem_in  = '0;
         den_in  = (sel == DIV_GAIN) ? GAIN_DEN : DR_DEN;
      end else if (busy_ff) begin
         rem_in = ge ? diff[44:0] : sh[44:0];
         dvd_in = {dvd_ff[62:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

[sv/gps_dead_reckoning_fusion_core.sv]
// gps / dead-reckoning fusion core: sequencer around a serial multiplier and divider
// each product is formed in the shift-add multiplier, each quotient in the divider
// one transaction at a time; a new one is taken while the previous result waits
// reset is synchronous and active high; control, configuration and fusion state reset,
// the latched transaction, working and result data registers do not
module gps_dead_reckoning_fusion_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [33:0]        req_easting_mm,
   input  logic [33:0]        req_northing_mm,
   input  logic [15:0]        req_yaw_angle,
   input  logic signed [17:0] req_speed_mm_s,
   input  logic [63:0]        req_position_stamp_ns,
   input  logic               req_stationary,
   input  logic [63:0]        req_now_ns,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [39:0] rsp_pos_x_mm,
   output logic signed [39:0] rsp_pos_y_mm,
   output logic signed [17:0] rsp_speed_out_mm_s,
   output logic [15:0]        rsp_yaw_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [33:0]        csr_wdata
);
   import gdrf_pkg::*;

   function automatic logic signed [39:0] add_sat(input logic signed [39:0] base,
                                                  input logic neg, input logic [19:0] mag);
      logic signed [40:0] d;
      logic signed [40:0] s;
      d = $signed({21'b0, mag});
      if (neg) d = -d;
      s = $signed({base[39], base}) + d;
      if (s[40] != s[39]) return s[40] ? POS_MIN : POS_MAX;
      return s[39:0];
   endfunction

   function automatic logic signed [25:0] clamp_q(input logic signed [63:0] v,
                                                  input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
      if (v < lo) return lo[25:0];
      if (v > hi) return hi[25:0];
      return v[25:0];
   endfunction

   fsm_state_type state_ff, state_in;

   // configuration
   logic [33:0] east_off_ff, east_off_in;
   logic [33:0] north_off_ff, north_off_in;
   logic [29:0] max_pred_ff, max_pred_in;

   // fusion state
   logic               init_ff, init_in;
   logic signed [39:0] lx_ff, lx_in;
   logic signed [39:0] ly_ff, ly_in;
   logic signed [17:0] fspd_ff, fspd_in;
   logic [63:0]        last_upd_ff, last_upd_in;
   logic [63:0]        last_stamp_ff, last_stamp_in;

   // latched transaction
   logic [33:0]        east_ff, east_in;
   logic [33:0]        north_ff, north_in;
   logic [15:0]        yaw_ff, yaw_in;
   logic signed [17:0] spd_ff, spd_in;
   logic [63:0]        stamp_ff, stamp_in;
   logic               stat_ff, stat_in;
   logic [63:0]        now_ff, now_in;

   // working registers
   logic signed [34:0] gx_ff, gx_in;
   logic signed [34:0] gy_ff, gy_in;
   logic [29:0]        dt_ff, dt_in;
   logic [16:0]        zs_ff, zs_in;
   logic [16:0]        zc_ff, zc_in;
   logic [16:0]        z2_ff, z2_in;
   logic [16:0]        t_ff, t_in;
   logic [14:0]        smag_ff, smag_in;
   logic [14:0]        cmag_ff, cmag_in;
   logic               sneg_ff, sneg_in;
   logic               cneg_ff, cneg_in;
   logic               ch_ff, ch_in;
   logic               ax_ff, ax_in;
   logic signed [41:0] ix_ff, ix_in;
   logic signed [41:0] iy_ff, iy_in;
   logic signed [25:0] fwd_ff, fwd_in;
   logic signed [25:0] lat_ff, lat_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               issued_ff, issued_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [39:0] rsp_x_ff, rsp_x_in;
   logic signed [39:0] rsp_y_ff, rsp_y_in;
   logic signed [17:0] rsp_spd_ff, rsp_spd_in;
   logic [15:0]        rsp_yaw_ff, rsp_yaw_in;

   // shared units
   logic               mul_start, mul_neg, mul_done;
   logic [47:0]        mul_a;
   logic [31:0]        mul_b;
   logic signed [63:0] mul_p;
   logic               div_start, div_done;
   div_sel_type        div_sel;
   logic [63:0]        div_dvd;
   logic [63:0]        div_q;
   logic               in_mul, in_div;

   // combinational helpers
   logic [15:0]        yk;
   logic [15:0]        xq;
   logic [17:0]        yr;
   logic [16:0]        yq;
   logic [14:0]        ymag;
   logic [17:0]        vmag;
   logic               vneg;
   logic [41:0]        ixm;
   logic [41:0]        iym;
   logic [25:0]        fwdm;
   logic [25:0]        latm;
   logic [63:0]        accm;
   logic [63:0]        tdiff;
   logic signed [63:0] fsum;
   logic               load_out;

   gdrf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .neg   (mul_neg),
      .a_mag (mul_a),
      .b_mag (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   gdrf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sel      (div_sel),
      .dividend (div_dvd),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         east_off_ff   <= '0;
         north_off_ff  <= '0;
         max_pred_ff   <= MAX_PRED_RESET;
         init_ff       <= 1'b0;
         lx_ff         <= '0;
         ly_ff         <= '0;
         fspd_ff       <= '0;
         last_upd_ff   <= '0;
         last_stamp_ff <= '0;
         issued_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         east_off_ff   <= east_off_in;
         north_off_ff  <= north_off_in;
         max_pred_ff   <= max_pred_in;
         init_ff       <= init_in;
         lx_ff         <= lx_in;
         ly_ff         <= ly_in;
         fspd_ff       <= fspd_in;
         last_upd_ff   <= last_upd_in;
         last_stamp_ff <= last_stamp_in;
         issued_ff     <= issued_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      east_ff    <= east_in;
      north_ff   <= north_in;
      yaw_ff     <= yaw_in;
      spd_ff     <= spd_in;
      stamp_ff   <= stamp_in;
      stat_ff    <= stat_in;
      now_ff     <= now_in;
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      dt_ff      <= dt_in;
      zs_ff      <= zs_in;
      zc_ff      <= zc_in;
      z2_ff      <= z2_in;
      t_ff       <= t_in;
      smag_ff    <= smag_in;
      cmag_ff    <= cmag_in;
      sneg_ff    <= sneg_in;
      cneg_ff    <= cneg_in;
      ch_ff      <= ch_in;
      ax_ff      <= ax_in;
      ix_ff      <= ix_in;
      iy_ff      <= iy_in;
      fwd_ff     <= fwd_in;
      lat_ff     <= lat_in;
      acc_ff     <= acc_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_spd_ff <= rsp_spd_in;
      rsp_yaw_ff <= rsp_yaw_in;
   end

   always_comb begin
      state_in      = state_ff;
      east_off_in   = east_off_ff;
      north_off_in  = north_off_ff;
      max_pred_in   = max_pred_ff;
      init_in       = init_ff;
      lx_in         = lx_ff;
      ly_in         = ly_ff;
      fspd_in       = fspd_ff;
      last_upd_in   = last_upd_ff;
      last_stamp_in = last_stamp_ff;
      east_in       = east_ff;
      north_in      = north_ff;
      yaw_in        = yaw_ff;
      spd_in        = spd_ff;
      stamp_in      = stamp_ff;
      stat_in       = stat_ff;
      now_in        = now_ff;
      gx_in         = gx_ff;
      gy_in         = gy_ff;
      dt_in         = dt_ff;
      zs_in         = zs_ff;
      zc_in         = zc_ff;
      z2_in         = z2_ff;
      t_in          = t_ff;
      smag_in       = smag_ff;
      cmag_in       = cmag_ff;
      sneg_in       = sneg_ff;
      cneg_in       = cneg_ff;
      ch_in         = ch_ff;
      ax_in         = ax_ff;
      ix_in         = ix_ff;
      iy_in         = iy_ff;
      fwd_in        = fwd_ff;
      lat_in        = lat_ff;
      acc_in        = acc_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_spd_in    = rsp_spd_ff;
      rsp_yaw_in    = rsp_yaw_ff;
      load_out      = 1'b0;

      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      div_dvd = '0;
      div_sel = DIV_DR;

      yk    = yaw_ff & YAW_MASK;
      xq    = {yk[13:0], 2'b00};
      yr    = mul_p[33:16] + 18'd1;
      yq    = yr[17:1];
      ymag  = (yq > SIN_MAX) ? SIN_MAX[14:0] : yq[14:0];
      vneg  = fspd_ff[17];
      vmag  = vneg ? 18'(-fspd_ff) : 18'(fspd_ff);
      ixm   = ix_ff[41] ? 42'(-ix_ff) : 42'(ix_ff);
      iym   = iy_ff[41] ? 42'(-iy_ff) : 42'(iy_ff);
      fwdm  = fwd_ff[25] ? 26'(-fwd_ff) : 26'(fwd_ff);
      latm  = lat_ff[25] ? 26'(-lat_ff) : 26'(lat_ff);
      accm  = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
      tdiff = now_ff - last_upd_ff;
      fsum  = acc_ff + mul_p;

      if (csr_valid) begin
         case (csr_index)
            CSR_EAST_OFFSET:  east_off_in  = csr_wdata;
            CSR_NORTH_OFFSET: north_off_in = csr_wdata;
            CSR_MAX_PRED:     max_pred_in  = csr_wdata[29:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               east_in  = req_easting_mm;
               north_in = req_northing_mm;
               yaw_in   = req_yaw_angle;
               spd_in   = req_speed_mm_s;
               stamp_in = req_position_stamp_ns;
               stat_in  = req_stationary;
               now_in   = req_now_ns;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            gx_in = $signed({1'b0, east_ff}) - $signed({1'b0, east_off_ff});
            gy_in = $signed({1'b0, north_ff}) - $signed({1'b0, north_off_ff});
            // stale or backward clock falls back to the cap
            if (last_upd_ff == '0 || now_ff < last_upd_ff) begin
               dt_in = max_pred_ff;
            end else if (tdiff > {34'b0, max_pred_ff}) begin
               dt_in = max_pred_ff;
            end else begin
               dt_in = tdiff[29:0];
            end
            zs_in   = yk[14] ? SIN_QUAD_ONE - {1'b0, xq} : {1'b0, xq};
            zc_in   = yk[14] ? {1'b0, xq} : SIN_QUAD_ONE - {1'b0, xq};
            sneg_in = yk[15];
            cneg_in = yk[15] ^ yk[14];
            ch_in   = 1'b0;
            state_in = ST_SIN_SQ;
         end
         ST_SIN_SQ: begin
            mul_a = {31'b0, ch_ff ? zc_ff : zs_ff};
            mul_b = {15'b0, ch_ff ? zc_ff : zs_ff};
            if (mul_done) begin
               z2_in    = mul_p[32:16];
               state_in = ST_SIN_T1;
            end
         end
         ST_SIN_T1: begin
            mul_a = {31'b0, z2_ff};
            mul_b = SIN_C3;
            if (mul_done) begin
               t_in     = SIN_C2 - {1'b0, mul_p[31:16]};
               state_in = ST_SIN_T2;
            end
         end
         ST_SIN_T2: begin
            mul_a = {31'b0, t_ff};
            mul_b = {15'b0, z2_ff};
            if (mul_done) begin
               t_in     = SIN_C1 - mul_p[32:16];
               state_in = ST_SIN_Y;
            end
         end
         ST_SIN_Y: begin
            mul_a = {31'b0, t_ff};
            mul_b = {15'b0, ch_ff ? zc_ff : zs_ff};
            if (mul_done) begin
               if (!ch_ff) begin
                  smag_in  = ymag;
                  ch_in    = 1'b1;
                  state_in = ST_SIN_SQ;
               end else begin
                  cmag_in = ymag;
                  if (!init_ff) begin
                     // first transaction seeds the state
                     lx_in         = 40'(gx_ff);
                     ly_in         = 40'(gy_ff);
                     fspd_in       = spd_ff;
                     last_upd_in   = now_ff;
                     last_stamp_in = stamp_ff;
                     init_in       = 1'b1;
                     state_in      = ST_OUT;
                  end else if (dt_ff != '0) begin
                     ax_in    = 1'b0;
                     state_in = ST_DR_V;
                  end else begin
                     state_in = ST_FIX;
                  end
               end
            end
         end
         ST_DR_V: begin
            mul_a = {30'b0, vmag};
            mul_b = {17'b0, ax_ff ? smag_ff : cmag_ff};
            if (mul_done) begin
               acc_in   = mul_p;
               state_in = ST_DR_P;
            end
         end
         ST_DR_P: begin
            mul_a = acc_ff[47:0];
            mul_b = {2'b0, dt_ff};
            if (mul_done) begin
               acc_in   = mul_p;
               state_in = ST_DR_D;
            end
         end
         ST_DR_D: begin
            div_sel = DIV_DR;
            div_dvd = acc_ff + DR_HALF;
            if (div_done) begin
               if (!ax_ff) begin
                  lx_in    = add_sat(lx_ff, vneg ^ cneg_ff, div_q[19:0]);
                  ax_in    = 1'b1;
                  state_in = ST_DR_V;
               end else begin
                  ly_in    = add_sat(ly_ff, vneg ^ sneg_ff, div_q[19:0]);
                  state_in = ST_FIX;
               end
            end
         end
         ST_FIX: begin
            last_upd_in = now_ff;
            if (stamp_ff != '0 && stamp_ff != last_stamp_ff) begin
               ix_in    = {{7{gx_ff[34]}}, gx_ff} - {{2{lx_ff[39]}}, lx_ff};
               iy_in    = {{7{gy_ff[34]}}, gy_ff} - {{2{ly_ff[39]}}, ly_ff};
               state_in = ST_F1;
            end else begin
               if (stat_ff) fspd_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_F1: begin
            mul_a   = {6'b0, ixm};
            mul_b   = {17'b0, cmag_ff};
            mul_neg = ix_ff[41] ^ cneg_ff;
            if (mul_done) begin
               acc_in   = mul_p;
               state_in = ST_F2;
            end
         end
         ST_F2: begin
            mul_a   = {6'b0, iym};
            mul_b   = {17'b0, smag_ff};
            mul_neg = iy_ff[41] ^ sneg_ff;
            if (mul_done) begin
               fwd_in   = clamp_q(fsum, stat_ff ? FWD_LO_STILL : FWD_LO_MOVING, FWD_HI);
               state_in = ST_F3;
            end
         end
         ST_F3: begin
            mul_a   = {6'b0, ixm};
            mul_b   = {17'b0, smag_ff};
            mul_neg = ix_ff[41] ^ sneg_ff;
            if (mul_done) begin
               acc_in   = mul_p;
               state_in = ST_F4;
            end
         end
         ST_F4: begin
            mul_a   = {6'b0, iym};
            mul_b   = {17'b0, cmag_ff};
            mul_neg = iy_ff[41] ^ cneg_ff;
            if (mul_done) begin
               lat_in   = clamp_q(mul_p - acc_ff, LAT_LO, LAT_HI);
               state_in = ST_C1;
            end
         end
         ST_C1: begin
            mul_a   = {22'b0, fwdm};
            mul_b   = {17'b0, cmag_ff};
            mul_neg = fwd_ff[25] ^ cneg_ff;
            if (mul_done) begin
               acc_in   = mul_p;
               state_in = ST_C2;
            end
         end
         ST_C2: begin
            mul_a   = {22'b0, latm};
            mul_b   = {17'b0, smag_ff};
            mul_neg = lat_ff[25] ^ sneg_ff;
            if (mul_done) begin
               acc_in   = acc_ff - mul_p;
               state_in = ST_C3;
            end
         end
         ST_C3: begin
            mul_a   = accm[47:0];
            mul_b   = GAIN_NUM;
            mul_neg = acc_ff[63];
            if (mul_done) begin
               acc_in   = mul_p;
               state_in = ST_C4;
            end
         end
         ST_C4: begin
            div_sel = DIV_GAIN;
            div_dvd = accm + GAIN_HALF;
            if (div_done) begin
               lx_in    = add_sat(lx_ff, acc_ff[63], div_q[19:0]);
               state_in = ST_C5;
            end
         end
         ST_C5: begin
            mul_a   = {22'b0, fwdm};
            mul_b   = {17'b0, smag_ff};
            mul_neg = fwd_ff[25] ^ sneg_ff;
            if (mul_done) begin
               acc_in   = mul_p;
               state_in = ST_C6;
            end
         end
         ST_C6: begin
            mul_a   = {22'b0, latm};
            mul_b   = {17'b0, cmag_ff};
            mul_neg = lat_ff[25] ^ cneg_ff;
            if (mul_done) begin
               acc_in   = fsum;
               state_in = ST_C7;
            end
         end
         ST_C7: begin
            mul_a   = accm[47:0];
            mul_b   = GAIN_NUM;
            mul_neg = acc_ff[63];
            if (mul_done) begin
               acc_in   = mul_p;
               state_in = ST_C8;
            end
         end
         ST_C8: begin
            div_sel = DIV_GAIN;
            div_dvd = accm + GAIN_HALF;
            if (div_done) begin
               ly_in         = add_sat(ly_ff, acc_ff[63], div_q[19:0]);
               fspd_in       = (stat_ff || spd_ff[17]) ? '0 : spd_ff;
               last_stamp_in = stamp_ff;
               state_in      = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out   = 1'b1;
               rsp_x_in   = lx_ff;
               rsp_y_in   = ly_ff;
               rsp_spd_in = fspd_ff;
               rsp_yaw_in = yaw_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // start each unit once on entry to a step, then wait for its done pulse
   always_comb begin
      in_mul = state_ff inside {ST_SIN_SQ, ST_SIN_T1, ST_SIN_T2, ST_SIN_Y, ST_DR_V, ST_DR_P,
                                ST_F1, ST_F2, ST_F3, ST_F4, ST_C1, ST_C2, ST_C3,
                                ST_C5, ST_C6, ST_C7};
      in_div = state_ff inside {ST_DR_D, ST_C4, ST_C8};
      mul_start = in_mul && !issued_ff;
      div_start = in_div && !issued_ff;
      if (mul_done || div_done) begin
         issued_in = 1'b0;
      end else if (mul_start || div_start) begin
         issued_in = 1'b1;
      end else begin
         issued_in = issued_ff;
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x_mm       = rsp_x_ff;
   assign rsp_pos_y_mm       = rsp_y_ff;
   assign rsp_speed_out_mm_s = rsp_spd_ff;
   assign rsp_yaw_out        = rsp_yaw_ff;

endmodule

[tb/tb.sv]
// self-checking testbench for the gps dead-reckoning fusion core
`timescale 1ns / 100ps

module tb;
   import gdrf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 4000;
   localparam int DRAIN_CYCLES   = 1100;
   localparam int RANDOM_ITEMS   = 1730;
   localparam int TAIL_ITEMS     = 150;

   typedef struct {
      logic [33:0] easting;
      logic [33:0] northing;
      logic [15:0] yaw;
      logic signed [17:0] speed;
      logic [63:0] stamp;
      logic        still;
      logic [63:0] now;
   } fix_type;

   typedef struct {
      logic signed [39:0] pos_x;
      logic signed [39:0] pos_y;
      logic signed [17:0] speed;
      logic [15:0]        yaw;
   } fused_type;

   class fusion_scoreboard_type;
      longint unsigned east_off, north_off, pred_cap;
      bit              seeded;
      longint          est_x, est_y;
      longint          est_speed;
      longint unsigned last_time, last_stamp;
      fused_type       pending_q[$];
      int              errors;

      function new();
         east_off = 0;
         north_off = 0;
         pred_cap = MAX_PRED_RESET;
         seeded = 0;
         est_x = 0;
         est_y = 0;
         est_speed = 0;
         last_time = 0;
         last_stamp = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [33:0] value);
         case (idx)
            CSR_EAST_OFFSET: east_off = value;
            CSR_NORTH_OFFSET: north_off = value;
            CSR_MAX_PRED: pred_cap = value[29:0];
            default: ;
         endcase
      endfunction

      static function longint sat40(longint v);
         if (v > longint'(POS_MAX)) return longint'(POS_MAX);
         if (v < longint'(POS_MIN)) return longint'(POS_MIN);
         return v;
      endfunction

      static function longint rdiv(bit neg, longint unsigned mag, longint unsigned den);
         longint unsigned q;
         q = (mag + den / 2) / den;
         return neg ? -longint'(q) : longint'(q);
      endfunction

      static function longint rdiv_signed(longint num, longint unsigned den);
         return rdiv(num < 0, num < 0 ? longint'(-num) : num, den);
      endfunction

      static function longint sine(logic [31:0] phase);
         longint unsigned x, z, z2, t, y;
         x = phase[29:14];
         z = phase[30] ? 65536 - x : x;
         z2 = (z * z) >> 16;
         t = 42047 - ((4640 * z2) >> 16);
         t = 102944 - ((t * z2) >> 16);
         y = (((t * z) >> 16) + 1) >> 1;
         if (y > 32767) y = 32767;
         return phase[31] ? -longint'(y) : longint'(y);
      endfunction

      static function longint clampv(longint v, longint lo, longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void note(fix_type f);
         longint gx, gy, s, c, spd, ix, iy, fwd, lat, back, cx, cy;
         longint unsigned dt, vmag, cmag, smag;
         logic [31:0] ang, phase;
         fused_type r;
         gx = longint'(f.easting) - longint'(east_off);
         gy = longint'(f.northing) - longint'(north_off);
         spd = f.speed;
         ang = ({16'd0, f.yaw} << 4) >> (20 - ANGLE_BITS);
         phase = ang << (32 - ANGLE_BITS);
         s = sine(phase);
         c = sine(phase + 32'h40000000);
         if (!seeded) begin
            est_x = sat40(gx);
            est_y = sat40(gy);
            est_speed = spd;
            last_time = f.now;
            last_stamp = f.stamp;
            seeded = 1;
         end else begin
            if (last_time == 0 || f.now < last_time) dt = pred_cap;
            else dt = f.now - last_time;
            if (dt > pred_cap) dt = pred_cap;
            if (dt > 0) begin
               vmag = est_speed < 0 ? -est_speed : est_speed;
               cmag = c < 0 ? -c : c;
               smag = s < 0 ? -s : s;
               est_x = sat40(est_x + rdiv((est_speed < 0) != (c < 0),
                                          vmag * cmag * dt, DR_DEN));
               est_y = sat40(est_y + rdiv((est_speed < 0) != (s < 0),
                                          vmag * smag * dt, DR_DEN));
            end
            last_time = f.now;
            if (f.stamp != 0 && f.stamp != last_stamp) begin
               ix = gx - est_x;
               iy = gy - est_y;
               fwd = ix * c + iy * s;
               lat = -ix * s + iy * c;
               back = f.still ? FWD_LO_STILL : FWD_LO_MOVING;
               fwd = clampv(fwd, back, FWD_HI);
               lat = clampv(lat, LAT_LO, LAT_HI);
               cx = (fwd * c - lat * s) * 45;
               cy = (fwd * s + lat * c) * 45;
               est_x = sat40(est_x + rdiv_signed(cx, GAIN_DEN));
               est_y = sat40(est_y + rdiv_signed(cy, GAIN_DEN));
               est_speed = f.still ? 0 : (spd < 0 ? 0 : spd);
               last_stamp = f.stamp;
            end else if (f.still) begin
               est_speed = 0;
            end
         end
         r.pos_x = est_x[39:0];
         r.pos_y = est_y[39:0];
         r.speed = est_speed[17:0];
         r.yaw = f.yaw;
         pending_q.push_back(r);
      endfunction

      function void check(fused_type got);
         fused_type e;
         if (pending_q.size() == 0) begin
            $error("result with no transaction pending");
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (got.pos_x !== e.pos_x) begin
            $error("pos_x_mm expected %0d actual %0d", e.pos_x, got.pos_x);
            errors++;
         end
         if (got.pos_y !== e.pos_y) begin
            $error("pos_y_mm expected %0d actual %0d", e.pos_y, got.pos_y);
            errors++;
         end
         if (got.speed !== e.speed) begin
            $error("speed_out_mm_s expected %0d actual %0d", e.speed, got.speed);
            errors++;
         end
         if (got.yaw !== e.yaw) begin
            $error("yaw_out expected %0d actual %0d", e.yaw, got.yaw);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [33:0]        req_easting_mm;
   logic [33:0]        req_northing_mm;
   logic [15:0]        req_yaw_angle;
   logic signed [17:0] req_speed_mm_s;
   logic [63:0]        req_position_stamp_ns;
   logic               req_stationary;
   logic [63:0]        req_now_ns;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [39:0] rsp_pos_x_mm;
   logic signed [39:0] rsp_pos_y_mm;
   logic signed [17:0] rsp_speed_out_mm_s;
   logic [15:0]        rsp_yaw_out;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [33:0]        csr_wdata;

   fusion_scoreboard_type fusion_sb;
   int  fixes_taken;
   bit  tail_phase;
   int  stall_cycles;

   // drift state of the synthetic track
   longint unsigned track_now, track_stamp, track_e, track_n;

   gps_dead_reckoning_fusion_core i_dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   task automatic send_fix(fix_type f);
      req_valid <= 1;
      req_easting_mm <= f.easting;
      req_northing_mm <= f.northing;
      req_yaw_angle <= f.yaw;
      req_speed_mm_s <= f.speed;
      req_position_stamp_ns <= f.stamp;
      req_stationary <= f.still;
      req_now_ns <= f.now;
      do @(posedge clock); while (!req_ready);
      fusion_sb.note(f);
      fixes_taken++;
      if (!tail_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [33:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      fusion_sb.write_reg(idx, value);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (fusion_sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_fix(output fix_type f);
      int pick;
      f.yaw = 16'($urandom);
      f.speed = 18'($urandom_range(0, 200000) - 100000);
      f.still = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 9) == 0) begin
         // noise: every field but the stationary flag unconstrained
         f.easting = 34'({$urandom, $urandom});
         f.northing = 34'({$urandom, $urandom});
         f.speed = 18'($urandom);
         f.stamp = {$urandom, $urandom};
         f.now = {$urandom, $urandom};
         return;
      end
      track_now += $urandom_range(0, 150000000);
      if ($urandom_range(0, 40) == 0) track_now -= $urandom_range(0, 300000000);
      track_e += $urandom_range(0, 4000) - 2000;
      track_n += $urandom_range(0, 4000) - 2000;
      f.easting = 34'(track_e + $urandom_range(0, 1000));
      f.northing = 34'(track_n + $urandom_range(0, 1000));
      f.now = track_now;
      pick = $urandom_range(0, 9);
      if (pick < 6) track_stamp = track_now - $urandom_range(0, 20000000);
      f.stamp = (pick == 9) ? 64'd0 : track_stamp;
   endtask

   // directed corner cases, right after a fresh seed
   task automatic directed_fixes;
      fix_type f;
      f = '{34'd1500000, 34'd2600000, 16'd0, -18'sd100000, 64'd0, 1'b0, 64'd0};
      send_fix(f);   // first item: negative speed seeded, zero stamp kept
      f = '{34'd1500500, 34'd2600000, 16'd16384, 18'sd100000, 64'd5, 1'b0, 64'd50000000};
      send_fix(f);
      f.now = 64'd50000000;   // no elapsed time
      f.stamp = 64'd5;        // repeated stamp
      send_fix(f);
      f.yaw = 16'd32768; f.stamp = 64'd7; f.now = 64'd40000000; // clock runs back
      send_fix(f);
      f.yaw = 16'd49152; f.easting = 34'h3FFFFFFFF; f.northing = 34'h3FFFFFFFF;
      f.stamp = 64'd9; f.now = 64'hFFFFFFFFFFFFFFFF;
      send_fix(f);
      f.yaw = 16'hFFFF; f.easting = '0; f.northing = '0; f.stamp = 64'd11;
      f.speed = 18'sh1FFFF;
      send_fix(f);
      f.speed = -18'sh20000; f.stamp = 64'd13; f.still = 1'b1;
      send_fix(f);   // fix while stationary
      f.stamp = 64'd0; f.speed = 18'sd20000; f.still = 1'b1;
      send_fix(f);   // stationary without a fix
      f.still = 1'b0; f.stamp = 64'hFFFFFFFFFFFFFFFF; f.speed = -18'sd5;
      f.easting = 34'd1500000; f.northing = 34'd2600000;
      send_fix(f);   // fix with negative speed, moving
      f.stamp = 64'd0; f.yaw = 16'd8192;
      send_fix(f);
      for (int i = 0; i < 8; i++) begin
         f.yaw = 16'(i * 8191);
         f.stamp = 64'd100 + i;
         f.now = 64'd1000000 * i;
         f.easting = 34'd1500000 + (i % 2) * 34'd4000;
         f.northing = 34'd2600000 - (i % 3) * 34'd4000;
         f.still = i[0];
         f.speed = 18'(3000 * i);
         send_fix(f);
      end
   endtask

   initial begin
      fix_type f;
      logic [33:0] offs [4][2];
      logic [29:0] caps [4];
      int per_phase;
      fusion_sb = new();
      fixes_taken = 0;
      tail_phase = 0;
      reset = 1;
      req_valid = 0;
      req_easting_mm = 0;
      req_northing_mm = 0;
      req_yaw_angle = 0;
      req_speed_mm_s = 0;
      req_position_stamp_ns = 0;
      req_stationary = 0;
      req_now_ns = 0;
      csr_valid = 0;
      csr_index = CSR_EAST_OFFSET;
      csr_wdata = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_csr(CSR_EAST_OFFSET, 34'd1000000);
      write_csr(CSR_NORTH_OFFSET, 34'd2000000);
      write_csr(CSR_MAX_PRED, 34'd100000000);
      directed_fixes();
      drain();

      offs[0] = '{34'd0, 34'd0};
      offs[1] = '{34'h3FFFFFFFF, 34'h3FFFFFFFF};
      offs[2] = '{34'd4000000000, 34'd1000};
      offs[3] = '{34'd123456789, 34'd9999999999};
      caps[0] = 30'd0;
      caps[1] = 30'h3FFFFFFF;
      caps[2] = 30'd1000000000;
      caps[3] = 30'd100000000;
      per_phase = RANDOM_ITEMS / 4;
      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_EAST_OFFSET, offs[p][0]);
         write_csr(CSR_NORTH_OFFSET, offs[p][1]);
         write_csr(CSR_MAX_PRED, 34'(caps[p]));
         track_now = {$urandom_range(0, 255), $urandom};
         track_stamp = 0;
         track_e = {$urandom_range(0, 3), $urandom};
         track_n = {$urandom_range(0, 3), $urandom};
         for (int i = 0; i < per_phase; i++) begin
            if (p == 3 && i >= per_phase - TAIL_ITEMS) tail_phase = 1;
            random_fix(f);
            send_fix(f);
         end
         drain();
      end

      if (fusion_sb.errors == 0 && fusion_sb.pending_q.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off to back up the core
   initial begin
      bit long_done;
      long_done = 0;
      stall_cycles = 0;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_done && fixes_taken >= 400) begin
            long_done = 1;
            stall_cycles = LONG_HOLD;
         end else if (stall_cycles == 0 && !tail_phase && $urandom_range(0, 7) == 0) begin
            stall_cycles = $urandom_range(1, 12);
         end
         if (stall_cycles > 0) begin
            rsp_ready <= 0;
            stall_cycles--;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      fused_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.pos_x = rsp_pos_x_mm;
         got.pos_y = rsp_pos_y_mm;
         got.speed = rsp_speed_out_mm_s;
         got.yaw = rsp_yaw_out;
         fusion_sb.check(got);
      end
   end

   // watchdog: cycles since the last transaction on any channel
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

endmodule
